>>> hdl/isoe_pkg.sv
package isoe_pkg;

	localparam int STACK_DEPTH = 64;
	// RAM address and element count widths
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_PUSH      = 3'd0,
		OP_PRINT_ALL = 3'd1,
		OP_PRINT_TOP = 3'd2,
		OP_POP       = 3'd3,
		OP_ADD       = 3'd4,
		OP_SWAP      = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_REFILL,
		S_DUMP
	} state_t;

endpackage

>>> hdl/isoe_ram.sv
module isoe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/integer_stack_op_engine.sv
// Integer stack engine: a bounded LIFO of signed 32-bit integers driven by
// one opcode per input item.
// Input channel (s_*): s_tuser carries the opcode (push, print all, print
// top, pop, add, swap), s_tdata the value a push stores.
// Output channel (m_*): one result item per opcode, except print all on a
// non-empty stack, which gives one item per element, top first, with
// m_tlast set on the final item of the opcode.
// The top two elements live in registers; the rest sit in a 1-port-write,
// 1-port-read RAM with a registered read.
// Latency: the first result is registered at the accept edge and shows up
// on m_tvalid in the next cycle.
// Input pacing: push, print top, swap and short-stack errors leave the engine
// idle. Pop and add on three or more elements pass through a refill state that
// reloads the next-of-stack register from the RAM. Print all gives the top
// element at the accept and holds the input while it gives the rest, paced by
// the RAM read port and m_tready.
// Reset clears the element count and the output valid; RAM contents are
// left alone, entries above the count are never read.
// When the receiver stalls, the result holds in the output register and
// s_tready drops until it is taken; print all simply pauses.
module integer_stack_op_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] push_value
	input  logic [2:0]  s_tuser,  // [2:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] value, [32] has_value, [34:33] status, [39:35] zero
	output logic        m_tlast
);

	import isoe_pkg::*;

	state_t           state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [AW-1:0]    idx_q, idx_d;
	logic [31:0]      tos_q, tos_d;
	logic [31:0]      nos_q, nos_d;

	// output register
	logic             m_tvalid_q;
	logic [31:0]      out_value_q;
	logic             out_has_q;
	status_t          out_status_q;
	logic             out_last_q;

	logic             out_load;
	logic [31:0]      o_value;
	logic             o_has;
	status_t          o_status;
	logic             o_last;

	// RAM ports
	logic             wr_en, rd_en;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [31:0]      wr_data, rd_data;

	logic             out_free, accept;
	op_t              op;
	logic [CW-1:0]    cnt_m2, cnt_m3;
	logic             is_empty, is_full, ge2, ge3, at_nos;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);

	assign cnt_m2   = count_q - CW'(2);
	assign cnt_m3   = count_q - CW'(3);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q >= CW'(STACK_DEPTH));
	assign ge2      = (count_q >= CW'(2));
	assign ge3      = (count_q >= CW'(3));
	// dump pointer still on the register-held second element
	assign at_nos   = (idx_q == cnt_m2[AW-1:0]);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op) inside
						OP_POP, OP_ADD: if (ge3) state_d = S_REFILL;
						OP_PRINT_ALL:   if (ge2) state_d = S_DUMP;
						default:        state_d = S_IDLE;
					endcase
				end
			end
			S_REFILL: state_d = S_IDLE;
			S_DUMP: begin
				if (out_free && idx_q == '0) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath and result control
	always_comb begin
		out_load = 1'b0;
		o_value  = '0;
		o_has    = 1'b0;
		o_status = ST_OK;
		o_last   = 1'b1;
		rd_en    = 1'b0;
		rd_addr  = cnt_m3[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = cnt_m2[AW-1:0];
		wr_data  = nos_q;
		tos_d    = tos_q;
		nos_d    = nos_q;
		count_d  = count_q;
		idx_d    = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					out_load = 1'b1;
					unique case (op)
						OP_PUSH: begin
							if (is_full) begin
								o_status = ST_FULL;
							end else begin
								// spill second element to RAM
								wr_en   = ge2;
								nos_d   = tos_q;
								tos_d   = s_tdata;
								count_d = count_q + CW'(1);
							end
						end
						OP_PRINT_ALL: begin
							if (!is_empty) begin
								o_value = tos_q;
								o_has   = 1'b1;
								o_last  = (count_q == CW'(1));
								idx_d   = cnt_m2[AW-1:0];
							end
						end
						OP_PRINT_TOP: begin
							if (is_empty) begin
								o_status = ST_SHORT;
							end else begin
								o_value = tos_q;
								o_has   = 1'b1;
							end
						end
						OP_POP: begin
							if (is_empty) begin
								o_status = ST_SHORT;
							end else begin
								tos_d   = nos_q;
								count_d = count_q - CW'(1);
								rd_en   = ge3;
							end
						end
						OP_ADD: begin
							if (!ge2) begin
								o_status = ST_SHORT;
							end else begin
								tos_d   = tos_q + nos_q;
								count_d = count_q - CW'(1);
								rd_en   = ge3;
							end
						end
						OP_SWAP: begin
							if (!ge2) begin
								o_status = ST_SHORT;
							end else begin
								tos_d = nos_q;
								nos_d = tos_q;
							end
						end
						default: o_status = ST_OK;
					endcase
				end
			end
			S_REFILL: nos_d = rd_data;
			S_DUMP: begin
				if (out_free) begin
					out_load = 1'b1;
					o_value  = at_nos ? nos_q : rd_data;
					o_has    = 1'b1;
					o_last   = (idx_q == '0);
					// prefetch next element; read data lands after this edge
					if (idx_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = idx_q - AW'(1);
						idx_d   = idx_q - AW'(1);
					end
				end
			end
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= tos_d;
		nos_q <= nos_d;
		idx_q <= idx_d;
		if (out_load) begin
			out_value_q  <= o_value;
			out_has_q    <= o_has;
			out_status_q <= o_status;
			out_last_q   <= o_last;
		end
	end

	isoe_ram #(
		.WIDTH(32),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, out_status_q, out_has_q, out_value_q};
	assign m_tlast  = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("element count above stack depth");

	a_ram_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_IDLE && accept))
		else $error("RAM written outside an accepted push");

	a_refill_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REFILL) |=> (state_q == S_IDLE))
		else $error("refill lasted more than one cycle");

	a_dump_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP && out_load && idx_q != '0) |=> (m_tvalid && !m_tlast))
		else $error("print all ended early");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("input taken while busy");

endmodule

>>> bench/stack_op_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the stack engine, keeps its own copy of the stack,
// and checks every result item against the oldest reply still awaited.
module stack_op_checker
	import isoe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending,
	output int          items_seen,
	output int          replies_seen,
	output int          deepest,
	output int          full_hits,
	output int          short_hits
);

	typedef struct packed {
		logic [31:0] value;
		logic        has_value;
		status_t     status;
		logic        last;
	} reply_t;

	logic [31:0] stack_mem [STACK_DEPTH];
	int          level;
	reply_t      awaited_replies [$];
	reply_t      oldest;

	task automatic add_reply(logic [31:0] v, logic hv, status_t st, logic lst);
		reply_t r;
		r.value     = v;
		r.has_value = hv;
		r.status    = st;
		r.last      = lst;
		awaited_replies.push_back(r);
	endtask

	task automatic add_short();
		short_hits++;
		add_reply('0, 1'b0, ST_SHORT, 1'b1);
	endtask

	// one opcode against the local stack copy
	task automatic apply_stack_op(logic [2:0] op, logic [31:0] operand);
		logic [31:0] t;
		int          k;
		case (op)
			OP_PUSH: begin
				if (level >= STACK_DEPTH) begin
					full_hits++;
					add_reply('0, 1'b0, ST_FULL, 1'b1);
				end else begin
					stack_mem[level] = operand;
					level++;
					add_reply('0, 1'b0, ST_OK, 1'b1);
				end
			end
			OP_PRINT_ALL: begin
				if (level == 0)
					add_reply('0, 1'b0, ST_OK, 1'b1);
				else
					for (k = 0; k < level; k++)
						add_reply(stack_mem[level - 1 - k], 1'b1, ST_OK, k == level - 1);
			end
			OP_PRINT_TOP: begin
				if (level == 0)
					add_short();
				else
					add_reply(stack_mem[level - 1], 1'b1, ST_OK, 1'b1);
			end
			OP_POP: begin
				if (level == 0) begin
					add_short();
				end else begin
					level--;
					add_reply('0, 1'b0, ST_OK, 1'b1);
				end
			end
			OP_ADD: begin
				if (level < 2) begin
					add_short();
				end else begin
					stack_mem[level - 2] = stack_mem[level - 2] + stack_mem[level - 1];
					level--;
					add_reply('0, 1'b0, ST_OK, 1'b1);
				end
			end
			OP_SWAP: begin
				if (level < 2) begin
					add_short();
				end else begin
					t                    = stack_mem[level - 1];
					stack_mem[level - 1] = stack_mem[level - 2];
					stack_mem[level - 2] = t;
					add_reply('0, 1'b0, ST_OK, 1'b1);
				end
			end
			default: add_reply('0, 1'b0, ST_OK, 1'b1);  // spare opcodes do nothing
		endcase
		if (level > deepest)
			deepest = level;
	endtask

	task automatic report_mismatch(string what);
		fail_count++;
		if (fail_count <= 40)
			$display("MISMATCH @%0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level        = 0;
			fail_count   = 0;
			pending      = 0;
			items_seen   = 0;
			replies_seen = 0;
			deepest      = 0;
			full_hits    = 0;
			short_hits   = 0;
			awaited_replies.delete();
		end else begin
			// results first: a result never belongs to an item taken at the same edge
			if (m_tvalid && m_tready) begin
				replies_seen++;
				if (awaited_replies.size() == 0) begin
					report_mismatch($sformatf("unexpected result data=%h last=%b",
						m_tdata, m_tlast));
				end else begin
					oldest = awaited_replies.pop_front();
					if (m_tdata[31:0] !== oldest.value)
						report_mismatch($sformatf("value %h, want %h",
							m_tdata[31:0], oldest.value));
					if (m_tdata[32] !== oldest.has_value)
						report_mismatch($sformatf("has_value %b, want %b",
							m_tdata[32], oldest.has_value));
					if (m_tdata[34:33] !== oldest.status)
						report_mismatch($sformatf("status %0d, want %0d",
							m_tdata[34:33], oldest.status));
					if (m_tdata[39:35] !== 5'd0)
						report_mismatch($sformatf("pad bits %b not zero", m_tdata[39:35]));
					if (m_tlast !== oldest.last)
						report_mismatch($sformatf("last %b, want %b", m_tlast, oldest.last));
				end
			end
			if (s_tvalid && s_tready) begin
				items_seen++;
				apply_stack_op(s_tuser, s_tdata);
			end
			pending = awaited_replies.size();
		end
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import isoe_pkg::*;

	// opcodes the engine treats as no-ops
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	localparam int RANDOM_ITEMS = 290;
	localparam int MODE_FILL    = 0;
	localparam int MODE_DRAIN   = 1;
	localparam int MODE_MIX     = 2;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] push_value
	logic [2:0]  s_tuser;   // [2:0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] value, [32] has_value, [34:33] status, [39:35] zero
	logic        m_tlast;

	int fail_count, pending, items_seen, replies_seen, deepest, full_hits, short_hits;

	int burst_left;
	int est_depth;   // rough stack depth, only used to steer the opcode mix

	integer_stack_op_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	stack_op_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.pending      (pending),
		.items_seen   (items_seen),
		.replies_seen (replies_seen),
		.deepest      (deepest),
		.full_hits    (full_hits),
		.short_hits   (short_hits)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop. It allows more than four times the worst case of ~380 items x 64
	// results, each result held back by the longest receiver stall.
	initial begin
		#3_000_000;
		$display("integer_stack_op_engine regression: fail");
		$finish;
	end

	// Receiver: switches between stall patterns at the end of each random phase so
	// stalls land on single results and in the middle of print-all dumps.
	initial begin : receiver
		int  phase_cycles;
		int  pattern;
		int  hold;
		int  tick;
		bit  stall_now;
		m_tready     = 1'b0;
		phase_cycles = 0;
		pattern      = 0;
		hold         = 0;
		tick         = 0;
		stall_now    = 1'b0;
		forever begin
			@(posedge clk);
			if (phase_cycles == 0) begin
				pattern      = $urandom_range(3);
				phase_cycles = $urandom_range(300, 60);
			end
			phase_cycles--;
			tick++;
			case (pattern)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(9) < 7);
				2: m_tready <= (tick % 3 != 0);
				default: begin
					// alternating ready and stall runs of random length
					if (hold == 0) begin
						stall_now = !stall_now;
						hold      = stall_now ? $urandom_range(12, 1) : $urandom_range(8, 1);
					end
					hold--;
					m_tready <= !stall_now;
				end
			endcase
		end
	end

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(9))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_op(int mode);
		int r;
		r = $urandom_range(99);
		if (r < 2)
			return (r == 0) ? OP_SPARE_6 : OP_SPARE_7;
		case (mode)
			MODE_FILL: begin
				if (r < 70) return OP_PUSH;
				if (r < 74) return OP_PRINT_ALL;
				if (r < 80) return OP_PRINT_TOP;
				if (r < 86) return OP_POP;
				if (r < 93) return OP_ADD;
				return OP_SWAP;
			end
			MODE_DRAIN: begin
				if (r < 20) return OP_PUSH;
				if (r < 28) return OP_PRINT_ALL;
				if (r < 38) return OP_PRINT_TOP;
				if (r < 65) return OP_POP;
				if (r < 88) return OP_ADD;
				return OP_SWAP;
			end
			default: begin
				if (r < 35) return OP_PUSH;
				if (r < 45) return OP_PRINT_ALL;
				if (r < 55) return OP_PRINT_TOP;
				if (r < 70) return OP_POP;
				if (r < 85) return OP_ADD;
				return OP_SWAP;
			end
		endcase
	endfunction

	// Offers one item and returns once it is taken. Items come in bursts;
	// a random gap (possibly none) opens each new burst.
	task automatic send_item(logic [2:0] op, logic [31:0] operand);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
			gap        = $urandom_range(5);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= operand;
		do @(posedge clk); while (!s_tready);
		case (op)
			OP_PUSH: if (est_depth < STACK_DEPTH) est_depth++;
			OP_POP:  if (est_depth > 0) est_depth--;
			OP_ADD:  if (est_depth >= 2) est_depth--;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		int mode;
		int i;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		burst_left = 0;
		est_depth  = 0;
		mode       = MODE_MIX;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every opcode on an empty stack, then extremes and wrap
		send_item(OP_PRINT_ALL, 32'h0);
		send_item(OP_PRINT_TOP, 32'h0);
		send_item(OP_POP, 32'h0);
		send_item(OP_ADD, 32'h0);
		send_item(OP_SWAP, 32'h0);
		send_item(OP_PUSH, 32'h7fff_ffff);
		send_item(OP_ADD, 32'hffff_ffff);     // only one element
		send_item(OP_SWAP, 32'h0);            // only one element
		send_item(OP_PUSH, 32'h0000_0001);
		send_item(OP_ADD, 32'h0);             // max + 1 wraps to min
		send_item(OP_PRINT_TOP, 32'h0);
		send_item(OP_PUSH, 32'hffff_ffff);
		send_item(OP_PUSH, 32'h8000_0000);
		send_item(OP_SWAP, 32'h0);
		send_item(OP_PRINT_ALL, 32'h0);
		send_item(OP_ADD, 32'h0);             // -1 + min wraps to max
		send_item(OP_PUSH, 32'h0);
		send_item(OP_SPARE_6, 32'hffff_ffff);
		send_item(OP_SPARE_7, 32'h1234_5678);
		send_item(OP_PRINT_ALL, 32'h0);
		send_item(OP_POP, 32'h0);
		send_item(OP_POP, 32'h0);
		send_item(OP_POP, 32'h0);
		send_item(OP_POP, 32'h0);             // empty again

		// fill to the top, push past it, dump the full stack
		repeat (STACK_DEPTH + 2) send_item(OP_PUSH, rand_operand());
		send_item(OP_PRINT_ALL, $urandom);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) begin
				// hold off until the engine has nothing left to deliver
				s_tvalid <= 1'b0;
				burst_left = 0;
				wait_drained();
			end
			if (i % 30 == 0) begin
				mode = $urandom_range(2);
				if (est_depth < 4)
					mode = MODE_FILL;
				else if (est_depth > 60 && $urandom_range(1) == 0)
					mode = MODE_DRAIN;
			end
			send_item(pick_op(mode), rand_operand());
		end
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);

		$display("covered %0d items, %0d results, deepest stack %0d",
			items_seen, replies_seen, deepest);
		$display("pushes onto a full stack: %0d, short-stack errors: %0d",
			full_hits, short_hits);
		if (fail_count == 0 && pending == 0)
			$display("integer_stack_op_engine regression: pass");
		else
			$display("integer_stack_op_engine regression: fail");
		$finish;
	end

endmodule
